[rtl/scp_pkg.sv]
// shared types and constants for the steering pd servo command block
`default_nettype none
package scp_pkg;

	// register indexes on the configuration channel
	localparam logic [1:0] CFG_DERIV_GAIN  = 2'd0;
	localparam logic [1:0] CFG_PROP_GAIN   = 2'd1;
	localparam logic [1:0] CFG_CENTER_LINE = 2'd2;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 10;

	// register reset values (prop gain 328 is 1.28 in q8)
	localparam logic [3:0] DERIV_GAIN_RESET  = 4'd0;
	localparam logic [9:0] PROP_GAIN_RESET   = 10'd328;
	localparam logic [7:0] CENTER_LINE_RESET = 8'd86;

	// command shaping
	localparam logic signed [15:0] RAW_LIMIT = 16'sd98;
	localparam logic [7:0] CMD_MID     = 8'd100;
	localparam logic [7:0] FULL_LEFT   = 8'd198;
	localparam logic [7:0] FULL_RIGHT  = 8'd2;
	localparam logic [7:0] LEFT_BELOW  = 8'd160;
	localparam logic [7:0] RIGHT_ABOVE = 8'd40;
	localparam logic [7:0] CMD_MAX     = 8'd200;

	// servo pwm mapping: base + cmd * span / cmd_max
	localparam logic [15:0] PWM_BASE  = 16'd1637;
	localparam logic [15:0] PWM_SPAN  = 16'd476;
	localparam logic [15:0] PWM_RESET = 16'd1880;
	localparam logic [15:0] PWM_TOP   = 16'd2113;

	typedef struct packed {
		logic [7:0] line_position;
		logic       turn_left;
		logic       turn_right;
		logic       hold_command;
		logic       robust_turn;
		logic [7:0] robust_angle;
		logic       output_enable;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  steer_command;
		logic [15:0] pwm_compare;
		logic        pwm_updated;
	} out_item_t;

	typedef struct packed {
		logic [CFG_INDEX_W-1:0] index;
		logic [CFG_DATA_W-1:0]  data;
	} cfg_item_t;

endpackage
`default_nettype wire

[rtl/scp_in_if.sv]
// frame input channel
`default_nettype none
interface scp_in_if;
	logic               valid;
	logic               ready;
	scp_pkg::in_item_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/scp_out_if.sv]
// steering result channel
`default_nettype none
interface scp_out_if;
	logic               valid;
	logic               ready;
	scp_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/scp_cfg_if.sv]
// configuration write channel
`default_nettype none
interface scp_cfg_if;
	logic               valid;
	logic               ready;
	scp_pkg::cfg_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/steering_pd_servo_command.sv]
// steering pd servo command: top level with shift-add datapath
//
// usage
//   line_in  : one beat per camera frame with the measured line position and
//              the override flags (turn left/right, hold, robust turn, enable)
//   cmd_out  : one beat per input beat with the held steering command, the
//              applied servo pwm compare value and whether it was refreshed
//   cfg      : register writes (0 deriv gain, 1 prop gain q8, 2 centre line),
//              always ready, to be used only while the block is idle
// timing
//   a shared shift-add unit takes one multiplier bit per cycle, in turn for the
//   derivative gain, the proportional gain and the pwm span, then 9 restoring
//   divide steps by 200 give the pwm offset one bit a cycle
//   the result is loaded into the output register from the done state; a new
//   beat can be taken in the next cycle, so frames are taken one at a time
// reset
//   arst_n clears the state: previous line 0, held command 0, compare 1880,
//   registers back to 0 / 328 / 86, no result pending
// back-pressure
//   the output register holds a result until it is taken; the next frame is
//   still taken and computed meanwhile and waits in its last step for the
//   output register to free up
`default_nettype none
module steering_pd_servo_command (
	input  wire logic   clk,
	input  wire logic   arst_n,
	scp_in_if.sink      line_in,
	scp_out_if.source   cmd_out,
	scp_cfg_if.sink     cfg
);

	// sequencer codes
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL_D = 3'd1;  // deriv_gain * diff, added onto position
	localparam logic [2:0] ST_ERR   = 3'd2;  // error against centre line
	localparam logic [2:0] ST_MUL_P = 3'd3;  // prop_gain * error
	localparam logic [2:0] ST_RAW   = 3'd4;  // scale, clamp, overrides
	localparam logic [2:0] ST_MUL_C = 3'd5;  // command * pwm span
	localparam logic [2:0] ST_DIV   = 3'd6;  // divide by 200, quotient bit per cycle
	localparam logic [2:0] ST_DONE  = 3'd7;  // hand over to the output register

	localparam int           ACC_W     = 24;
	localparam int           QUOT_W    = 9;
	localparam logic [3:0]   STEPS_D   = 4'd4;
	localparam logic [3:0]   STEPS_P   = 4'd10;
	localparam logic [3:0]   STEPS_C   = 4'd8;
	localparam logic [3:0]   STEPS_DIV = 4'd9;
	// divisor aligned to the top quotient bit
	localparam logic signed [ACC_W-1:0] DIV_INIT =
		ACC_W'({8'd0, scp_pkg::CMD_MAX} << (QUOT_W - 1));

	logic [2:0] state_q;
	logic [3:0] cnt_q;

	// configuration registers
	logic [3:0] deriv_gain_q;
	logic [9:0] prop_gain_q;
	logic [7:0] center_line_q;

	// block state
	logic [7:0]  prev_line_q;
	logic [7:0]  held_cmd_q;
	logic [15:0] compare_q;

	// frame flags kept for the whole computation
	logic       left_q, right_q, hold_q, robust_q, enable_q;
	logic [7:0] angle_q;

	// shared shift-add / restoring divide datapath
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] mcand_q;
	logic [9:0]              mplier_q;

	// output register
	logic                out_valid_q;
	scp_pkg::out_item_t  out_q;

	logic in_beat, out_beat, out_free, out_load;

	assign line_in.ready = (state_q == ST_IDLE);
	assign in_beat       = line_in.valid && line_in.ready;
	assign out_beat      = out_valid_q && cmd_out.ready;
	assign out_free      = !out_valid_q || cmd_out.ready;
	assign out_load      = (state_q == ST_DONE) && out_free;
	assign cmd_out.valid = out_valid_q;
	assign cmd_out.data  = out_q;
	assign cfg.ready     = 1'b1;

	// operands of the derivative and error steps
	logic signed [9:0] diff;
	assign diff = signed'({2'b00, line_in.data.line_position}) - signed'({2'b00, prev_line_q});

	logic signed [ACC_W-1:0] err;
	assign err = signed'({{(ACC_W-8){1'b0}}, center_line_q}) - acc_q;

	// one step of the shift-add unit
	logic signed [ACC_W-1:0] acc_add;
	assign acc_add = mplier_q[0] ? (acc_q + mcand_q) : acc_q;

	// scale by 1/256 truncating toward zero, clamp, recentre
	logic signed [ACC_W-1:0] raw_round;
	logic signed [15:0]      raw_div;
	logic signed [15:0]      raw_clip;
	logic [7:0]              raw_cmd;
	logic [7:0]              turn_cmd;
	logic [7:0]              new_held;
	logic [7:0]              pwm_cmd;

	assign raw_round = acc_q + (acc_q[ACC_W-1] ? ACC_W'(255) : ACC_W'(0));
	assign raw_div   = raw_round[ACC_W-1:8];

	always_comb begin
		priority if (raw_div > scp_pkg::RAW_LIMIT) begin
			raw_clip = scp_pkg::RAW_LIMIT;
		end else if (raw_div < -scp_pkg::RAW_LIMIT) begin
			raw_clip = -scp_pkg::RAW_LIMIT;
		end else begin
			raw_clip = raw_div;
		end
	end

	assign raw_cmd = raw_clip[7:0] + scp_pkg::CMD_MID;

	// turn overrides: left first, right wins where its condition holds
	always_comb begin
		turn_cmd = raw_cmd;
		if (left_q && (turn_cmd == scp_pkg::FULL_LEFT || turn_cmd < scp_pkg::LEFT_BELOW)) begin
			turn_cmd = scp_pkg::FULL_LEFT;
		end
		if (right_q && (turn_cmd == scp_pkg::FULL_RIGHT || turn_cmd > scp_pkg::RIGHT_ABOVE)) begin
			turn_cmd = scp_pkg::FULL_RIGHT;
		end
	end

	always_comb begin
		new_held = hold_q ? held_cmd_q : turn_cmd;
		if (robust_q) begin
			new_held = angle_q;
		end
	end

	assign pwm_cmd = (new_held > scp_pkg::CMD_MAX) ? scp_pkg::CMD_MAX : new_held;

	logic [15:0] pwm_new;
	assign pwm_new = scp_pkg::PWM_BASE + {7'd0, mplier_q[QUOT_W-1:0]};

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deriv_gain_q  <= scp_pkg::DERIV_GAIN_RESET;
			prop_gain_q   <= scp_pkg::PROP_GAIN_RESET;
			center_line_q <= scp_pkg::CENTER_LINE_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.data.index)
				scp_pkg::CFG_DERIV_GAIN:  deriv_gain_q  <= cfg.data.data[3:0];
				scp_pkg::CFG_PROP_GAIN:   prop_gain_q   <= cfg.data.data[9:0];
				scp_pkg::CFG_CENTER_LINE: center_line_q <= cfg.data.data[7:0];
				default: ;
			endcase
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= 4'd0;
			prev_line_q <= 8'd0;
			held_cmd_q  <= 8'd0;
			compare_q   <= scp_pkg::PWM_RESET;
			out_valid_q <= 1'b0;
		end else begin
			// a new result replaces the one taken in the same cycle
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_beat) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						prev_line_q <= line_in.data.line_position;
						cnt_q       <= STEPS_D;
						state_q     <= ST_MUL_D;
					end
				end
				ST_MUL_D: begin
					cnt_q <= cnt_q - 4'd1;
					if (cnt_q == 4'd1) begin
						state_q <= ST_ERR;
					end
				end
				ST_ERR: begin
					cnt_q   <= STEPS_P;
					state_q <= ST_MUL_P;
				end
				ST_MUL_P: begin
					cnt_q <= cnt_q - 4'd1;
					if (cnt_q == 4'd1) begin
						state_q <= ST_RAW;
					end
				end
				ST_RAW: begin
					held_cmd_q <= new_held;
					cnt_q      <= STEPS_C;
					state_q    <= ST_MUL_C;
				end
				ST_MUL_C: begin
					if (cnt_q == 4'd1) begin
						cnt_q   <= STEPS_DIV;
						state_q <= ST_DIV;
					end else begin
						cnt_q <= cnt_q - 4'd1;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 4'd1;
					if (cnt_q == 4'd1) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						if (enable_q) begin
							compare_q <= pwm_new;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath and payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_beat) begin
					left_q   <= line_in.data.turn_left;
					right_q  <= line_in.data.turn_right;
					hold_q   <= line_in.data.hold_command;
					robust_q <= line_in.data.robust_turn;
					angle_q  <= line_in.data.robust_angle;
					enable_q <= line_in.data.output_enable;
					acc_q    <= signed'({{(ACC_W-8){1'b0}}, line_in.data.line_position});
					mcand_q  <= ACC_W'(diff);
					mplier_q <= {6'd0, deriv_gain_q};
				end
			end
			ST_MUL_D, ST_MUL_P: begin
				acc_q    <= acc_add;
				mcand_q  <= mcand_q <<< 1;
				mplier_q <= mplier_q >> 1;
			end
			ST_ERR: begin
				mcand_q  <= err;
				mplier_q <= prop_gain_q;
				acc_q    <= '0;
			end
			ST_RAW: begin
				mcand_q  <= signed'(ACC_W'(scp_pkg::PWM_SPAN));
				mplier_q <= {2'd0, pwm_cmd};
				acc_q    <= '0;
			end
			ST_MUL_C: begin
				acc_q <= acc_add;
				if (cnt_q == 4'd1) begin
					mcand_q  <= DIV_INIT;
					mplier_q <= '0;
				end else begin
					mcand_q  <= mcand_q <<< 1;
					mplier_q <= mplier_q >> 1;
				end
			end
			ST_DIV: begin
				if (acc_q >= mcand_q) begin
					acc_q    <= acc_q - mcand_q;
					mplier_q <= {mplier_q[8:0], 1'b1};
				end else begin
					mplier_q <= {mplier_q[8:0], 1'b0};
				end
				mcand_q <= mcand_q >>> 1;
			end
			ST_DONE: begin
				if (out_free) begin
					out_q.steer_command <= held_cmd_q;
					out_q.pwm_compare   <= enable_q ? pwm_new : compare_q;
					out_q.pwm_updated   <= enable_q;
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

[rtl/scp_checker.sv]
// port-level checks for the steering pd servo command block, with bind
`default_nettype none
module scp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [7:0]  steer_command,
	input wire logic [15:0] pwm_compare,
	input wire logic        pwm_updated
);

	// compare value of the last beat delivered
	logic [15:0] last_pwm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pwm_q <= scp_pkg::PWM_RESET;
		end else if (out_valid && out_ready) begin
			last_pwm_q <= pwm_compare;
		end
	end

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(steer_command)
			&& $stable(pwm_compare) && $stable(pwm_updated))
		else $error("result changed while stalled");

	// one frame in flight at a time
	a_one_frame: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("frame taken while busy");

	// a refreshed compare lies on the servo span
	a_pwm_span: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pwm_updated |-> pwm_compare >= scp_pkg::PWM_BASE
			&& pwm_compare <= scp_pkg::PWM_TOP)
		else $error("pwm compare outside servo span");

	// without refresh the compare value carries over from the last beat
	a_pwm_kept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !pwm_updated |-> pwm_compare == last_pwm_q)
		else $error("pwm compare changed without refresh");

endmodule

bind steering_pd_servo_command scp_checker u_scp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (line_in.valid),
	.in_ready      (line_in.ready),
	.out_valid     (cmd_out.valid),
	.out_ready     (cmd_out.ready),
	.steer_command (cmd_out.data.steer_command),
	.pwm_compare   (cmd_out.data.pwm_compare),
	.pwm_updated   (cmd_out.data.pwm_updated)
);
`default_nettype wire

[tb/servo_cmd_checker.sv]
// checker that predicts every steering result beat and compares it with the block
`timescale 1ns / 1ps
module servo_cmd_checker
	import scp_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	scp_in_if         line_in,
	scp_out_if        cmd_out,
	scp_cfg_if        cfg,
	output int        fail_count,
	output int        pending
);
	logic [3:0]  deriv_gain;
	logic [9:0]  prop_gain;
	logic [7:0]  centre;
	logic [7:0]  last_line;
	logic [7:0]  held_cmd;
	logic [15:0] compare;
	out_item_t   awaited_cmds[$];
	int          failures = 0;
	int          outstanding = 0;

	assign fail_count = failures;
	assign pending    = outstanding;

	// one pd step: updates the shadow state and returns the result it causes
	function automatic out_item_t servo_step(input in_item_t f);
		out_item_t r;
		int        slope;
		int        aim;
		int        turn;
		int        limited;
		slope = int'(f.line_position) - int'(last_line);
		aim   = int'(f.line_position) + int'(deriv_gain) * slope;
		turn  = (int'(prop_gain) * (int'(centre) - aim)) / 256;
		if (turn > int'(RAW_LIMIT))
			turn = int'(RAW_LIMIT);
		if (turn < -int'(RAW_LIMIT))
			turn = -int'(RAW_LIMIT);
		turn      = turn + int'(CMD_MID);
		last_line = f.line_position;
		if (!f.hold_command) begin
			if (f.turn_left && (turn == int'(FULL_LEFT) || turn < int'(LEFT_BELOW)))
				turn = int'(FULL_LEFT);
			if (f.turn_right && (turn == int'(FULL_RIGHT) || turn > int'(RIGHT_ABOVE)))
				turn = int'(FULL_RIGHT);
			held_cmd = 8'(turn);
		end
		if (f.robust_turn)
			held_cmd = f.robust_angle;
		if (f.output_enable) begin
			limited = (held_cmd > CMD_MAX) ? int'(CMD_MAX) : int'(held_cmd);
			compare = 16'(int'(PWM_BASE) + limited * int'(PWM_SPAN) / int'(CMD_MAX));
		end
		r.steer_command = held_cmd;
		r.pwm_compare   = compare;
		r.pwm_updated   = f.output_enable;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		out_item_t want;
		if (!arst_n) begin
			deriv_gain = DERIV_GAIN_RESET;
			prop_gain  = PROP_GAIN_RESET;
			centre     = CENTER_LINE_RESET;
			last_line  = '0;
			held_cmd   = '0;
			compare    = PWM_RESET;
			awaited_cmds.delete();
		end else begin
			if (cmd_out.valid && cmd_out.ready) begin
				if (awaited_cmds.size() == 0) begin
					$error("cmd_out beat with no frame waiting for it");
					failures++;
				end else begin
					want = awaited_cmds.pop_front();
					if (cmd_out.data.steer_command !== want.steer_command) begin
						$error("steer_command: expected %0d, got %0d",
							want.steer_command, cmd_out.data.steer_command);
						failures++;
					end
					if (cmd_out.data.pwm_compare !== want.pwm_compare) begin
						$error("pwm_compare: expected %0d, got %0d",
							want.pwm_compare, cmd_out.data.pwm_compare);
						failures++;
					end
					if (cmd_out.data.pwm_updated !== want.pwm_updated) begin
						$error("pwm_updated: expected %0d, got %0d",
							want.pwm_updated, cmd_out.data.pwm_updated);
						failures++;
					end
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.data.index)
					CFG_DERIV_GAIN:  deriv_gain = cfg.data.data[3:0];
					CFG_PROP_GAIN:   prop_gain  = cfg.data.data;
					CFG_CENTER_LINE: centre     = cfg.data.data[7:0];
					default: ;
				endcase
			end
			if (line_in.valid && line_in.ready)
				awaited_cmds.push_back(servo_step(line_in.data));
		end
		outstanding = awaited_cmds.size();
	end

endmodule

[tb/tb_top.sv]
// top of the steering pd servo command testbench: stimulus, pacing and verdict
`timescale 1ns / 1ps
module tb_top;
	import scp_pkg::*;

	localparam int QUIET_LIMIT   = 2000; // cycles with no beat anywhere
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_FRAMES  = 50;
	localparam int TAIL_CYCLES   = 40;   // idle cycles after the last drain

	logic       clk;
	logic       arst_n;
	int         fail_count;
	int         pending;
	int         idle_pct;   // chance in percent of a pause before a beat, both sides
	logic [7:0] last_pos;   // last line position sent, to keep some steps small
	logic [7:0] centre_now; // centre line setting in force

	scp_in_if  line_if ();
	scp_out_if cmd_if ();
	scp_cfg_if cfg_if ();

	steering_pd_servo_command u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.line_in (line_if),
		.cmd_out (cmd_if),
		.cfg     (cfg_if)
	);

	servo_cmd_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.line_in    (line_if),
		.cmd_out    (cmd_if),
		.cfg        (cfg_if),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// builds one frame beat from its fields
	function automatic in_item_t frame(input logic [7:0] pos, input logic left,
		input logic right, input logic hold, input logic robust,
		input logic [7:0] angle, input logic en);
		in_item_t f;
		f.line_position = pos;
		f.turn_left     = left;
		f.turn_right    = right;
		f.hold_command  = hold;
		f.robust_turn   = robust;
		f.robust_angle  = angle;
		f.output_enable = en;
		return f;
	endfunction

	// random frame: positions either anywhere, near the centre or near the last one,
	// so that the derivative term is not always saturated
	function automatic in_item_t random_frame();
		in_item_t f;
		int       p;
		case ($urandom_range(0, 3))
			0:       p = int'($urandom_range(0, 255));
			1:       p = int'(centre_now) + int'($urandom_range(0, 40)) - 20;
			default: p = int'(last_pos) + int'($urandom_range(0, 16)) - 8;
		endcase
		if (p < 0)
			p = 0;
		if (p > 255)
			p = 255;
		f.line_position = 8'(p);
		f.turn_left     = ($urandom_range(0, 3) == 0);
		f.turn_right    = ($urandom_range(0, 3) == 0);
		f.hold_command  = ($urandom_range(0, 5) == 0);
		f.robust_turn   = ($urandom_range(0, 5) == 0);
		// angles above the servo range turn up now and then
		f.robust_angle  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
			: 8'($urandom_range(0, 200));
		f.output_enable = ($urandom_range(0, 3) != 0);
		return f;
	endfunction

	// sends one frame beat, sometimes after a pause; valid is left high so that
	// back-to-back beats need no toggling
	task automatic send_frame(input in_item_t f);
		if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
			line_if.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		line_if.valid <= 1'b1;
		line_if.data  <= f;
		do @(posedge clk); while (!line_if.ready);
		last_pos = f.line_position;
	endtask

	// one register write beat; the caller lowers valid once its writes are done
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		cfg_item_t w;
		w.index = idx;
		w.data  = value;
		cfg_if.valid <= 1'b1;
		cfg_if.data  <= w;
		do @(posedge clk); while (!cfg_if.ready);
	endtask

	task automatic program_regs(input logic [3:0] dg, input logic [9:0] pg,
		input logic [7:0] cl);
		write_reg(CFG_DERIV_GAIN, CFG_DATA_W'(dg));
		write_reg(CFG_PROP_GAIN, pg);
		write_reg(CFG_CENTER_LINE, CFG_DATA_W'(cl));
		cfg_if.valid <= 1'b0;
		centre_now = cl;
	endtask

	// stops sending and waits until every result of the frames sent has come back;
	// the extra edge lets the checker book the last accepted frame first
	task automatic drain();
		line_if.valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);
	endtask

	// result side: ready runs broken by stall bursts, none when idle_pct is 0
	initial begin : sink_pacing
		cmd_if.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
				cmd_if.ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end else begin
				cmd_if.ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	// ends the run if nothing moves on any channel for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((line_if.valid && line_if.ready) || (cmd_if.valid && cmd_if.ready)
				|| (cfg_if.valid && cfg_if.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("steering_pd_servo_command verification failed");
		$finish;
	end

	initial begin : stimulus
		arst_n        <= 1'b0;
		line_if.valid <= 1'b0;
		line_if.data  <= '0;
		cfg_if.valid  <= 1'b0;
		cfg_if.data   <= '0;
		idle_pct   = 0;
		last_pos   = '0;
		centre_now = CENTER_LINE_RESET;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part: proportional gain and centre stay at their reset values,
		// only the derivative gain is set so the first frame shows its effect
		write_reg(CFG_DERIV_GAIN, CFG_DATA_W'(2));
		cfg_if.valid <= 1'b0;
		idle_pct = 20;
		send_frame(frame(8'd200, 0, 0, 0, 0, 8'd0, 1)); // first frame, previous line 0
		send_frame(frame(8'd0, 0, 0, 0, 0, 8'd0, 1));
		send_frame(frame(8'd255, 0, 0, 0, 0, 8'd0, 1));
		send_frame(frame(8'd86, 0, 0, 0, 0, 8'd0, 1));
		send_frame(frame(8'd86, 0, 0, 0, 0, 8'd0, 1));   // dead ahead, command 100
		send_frame(frame(8'd255, 1, 0, 0, 0, 8'd0, 1));  // left forced from a low command
		send_frame(frame(8'd0, 1, 0, 0, 0, 8'd0, 1));    // left on a command already 198
		send_frame(frame(8'd31, 0, 0, 0, 0, 8'd0, 1));
		send_frame(frame(8'd31, 1, 0, 0, 0, 8'd0, 1));   // left ignored between 160 and 197
		send_frame(frame(8'd255, 0, 1, 0, 0, 8'd0, 1));
		send_frame(frame(8'd255, 0, 1, 0, 0, 8'd0, 1));  // right on a command already 2
		send_frame(frame(8'd86, 0, 1, 0, 0, 8'd0, 1));   // right forced from a high command
		send_frame(frame(8'd141, 0, 0, 0, 0, 8'd0, 1));
		send_frame(frame(8'd141, 0, 1, 0, 0, 8'd0, 1));  // right ignored between 3 and 40
		send_frame(frame(8'd86, 1, 1, 0, 0, 8'd0, 1));   // both flags, right wins
		send_frame(frame(8'd200, 1, 1, 1, 0, 8'd0, 1));  // hold masks the turn flags
		send_frame(frame(8'd90, 0, 0, 0, 1, 8'd255, 1)); // robust angle beyond the servo range
		send_frame(frame(8'd90, 0, 0, 1, 1, 8'd7, 1));   // robust turn while holding
		send_frame(frame(8'd120, 0, 0, 0, 1, 8'd0, 0));  // robust 0 with output disabled
		send_frame(frame(8'd60, 0, 0, 0, 1, 8'd200, 1));
		send_frame(frame(8'd60, 0, 0, 0, 0, 8'd0, 0));   // compare kept from before

		// register extremes: largest gains drive the widest error either way
		drain();
		program_regs(4'd15, 10'd1023, 8'd255);
		send_frame(frame(8'd0, 0, 0, 0, 0, 8'd0, 1));
		send_frame(frame(8'd255, 0, 0, 0, 0, 8'd0, 1));
		drain();
		program_regs(4'd15, 10'd1023, 8'd0);
		send_frame(frame(8'd0, 0, 0, 0, 0, 8'd0, 1));
		drain();
		program_regs(4'd0, 10'd0, 8'd128);
		send_frame(frame(8'd255, 0, 0, 0, 0, 8'd0, 1));  // zero gain gives straight ahead

		// random part: a fresh register setting per phase, with varying pressure;
		// the last phase runs with no pauses on either side
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			logic [3:0] dg;
			logic [9:0] pg;
			logic [7:0] cl;
			case ($urandom_range(0, 3))
				0:       dg = 4'd0;
				1:       dg = 4'd15;
				default: dg = 4'($urandom_range(0, 15));
			endcase
			case ($urandom_range(0, 4))
				0:       pg = 10'd0;
				1:       pg = 10'd1023;
				2:       pg = PROP_GAIN_RESET;
				default: pg = 10'($urandom_range(0, 1023));
			endcase
			case ($urandom_range(0, 3))
				0:       cl = 8'd0;
				1:       cl = 8'd255;
				default: cl = 8'($urandom_range(0, 255));
			endcase
			drain();
			program_regs(dg, pg, cl);
			case (ph % 4)
				0:       idle_pct = 0;
				1:       idle_pct = 15;
				2:       idle_pct = 35;
				default: idle_pct = 60;
			endcase
			if (ph == RANDOM_PHASES - 1)
				idle_pct = 0;
			repeat (PHASE_FRAMES) send_frame(random_frame());
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("steering_pd_servo_command verification clean");
		else
			$display("steering_pd_servo_command verification failed");
		$finish;
	end

endmodule

[files.f]
rtl/scp_pkg.sv
rtl/scp_in_if.sv
rtl/scp_out_if.sv
rtl/scp_cfg_if.sv
rtl/steering_pd_servo_command.sv
rtl/scp_checker.sv
tb/servo_cmd_checker.sv
tb/tb_top.sv
